/* rtl/core/lpht_pkg.sv */
// Shared types and constants for the linear probing hash table.
// No dependencies; used by every module of the block and its checker.
`timescale 1ns / 1ps

package lpht_pkg;

  // Field widths of the item and result ports
  localparam int KeyW    = 32;
  localparam int StatusW = 2;
  localparam int SlotW   = 4;

  // Default number of slots
  localparam int DefTableDepth = 16;

  // Key bits folded into the home slot remainder per cycle
  localparam int HashBitsPerStep = 4;

  typedef enum logic {
    ActInsert = 1'b0,
    ActSearch = 1'b1
  } action_e;

  typedef enum logic [StatusW-1:0] {
    StInserted = 2'd0,
    StFull     = 2'd1,
    StFound    = 2'd2,
    StNotFound = 2'd3
  } status_e;

  // Result of one item, handed from the probe engine to the output register
  typedef struct packed {
    status_e          status;
    logic [SlotW-1:0] slot;
  } res_t;

endpackage

/* rtl/core/lpht_hash.sv */
// Home slot unit: key modulo the table depth.
// Power-of-two depths take the low key bits; others run a restoring remainder,
// a few key bits per cycle. Depends on lpht_pkg.
`timescale 1ns / 1ps

module lpht_hash #(
  parameter int TableDepth = lpht_pkg::DefTableDepth,
  localparam int IdxW = $clog2(TableDepth)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lpht_pkg::KeyW-1:0] key_i,
  output logic                      done_o,
  output logic [IdxW-1:0]           home_o
);

  localparam bit IsPow2 = ((TableDepth & (TableDepth - 1)) == 0);

  if (IsPow2) begin : g_pow2
    logic            done_q;
    logic [IdxW-1:0] home_q;

    // Remainder is a mask of the low key bits; home slot and done are registered
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        home_q <= key_i[IdxW-1:0];
      end
    end

    assign done_o = done_q;
    assign home_o = home_q;
  end else begin : g_div
    localparam int BitsPerStep = lpht_pkg::HashBitsPerStep;
    localparam int Steps       = lpht_pkg::KeyW / BitsPerStep;
    localparam int StepW       = $clog2(Steps);
    localparam logic [StepW-1:0] LastStep = StepW'(Steps - 1);
    localparam logic [IdxW:0]    DepthC   = (IdxW + 1)'(TableDepth);

    logic                      busy_q;
    logic                      done_q;
    logic [StepW-1:0]          cnt_q;
    logic [IdxW-1:0]           rem_q, rem_d;
    logic [lpht_pkg::KeyW-1:0] sh_q, sh_d;
    logic [IdxW:0]             trial;

    // Restoring remainder, MSB first; trial stays below twice the depth
    always_comb begin
      rem_d = rem_q;
      sh_d  = sh_q;
      trial = '0;
      for (int b = 0; b < BitsPerStep; b++) begin
        trial = {rem_d, sh_d[lpht_pkg::KeyW-1]};
        if (trial >= DepthC) begin
          trial = trial - DepthC;
        end
        rem_d = trial[IdxW-1:0];
        sh_d  = sh_d << 1;
      end
    end

    // Step sequencing
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        done_q <= 1'b0;
        cnt_q  <= '0;
      end else begin
        done_q <= 1'b0;
        if (start_i) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end else if (busy_q) begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LastStep) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        sh_q  <= key_i;
        rem_q <= '0;
      end else if (busy_q) begin
        sh_q  <= sh_d;
        rem_q <= rem_d;
      end
    end

    assign done_o = done_q;
    assign home_o = rem_q;
  end

endmodule

/* rtl/core/lpht_probe.sv */
// Probe engine: slot memory (key plus occupied mark), clearing pass after reset,
// and the sequencer that walks slots from home. Depends on lpht_pkg.
`timescale 1ns / 1ps

module lpht_probe #(
  parameter int TableDepth = lpht_pkg::DefTableDepth,
  localparam int IdxW = $clog2(TableDepth)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  output logic                      idle_o,
  input  logic                      start_i,
  input  lpht_pkg::action_e         action_i,
  input  logic [lpht_pkg::KeyW-1:0] key_i,
  input  logic                      home_valid_i,
  input  logic [IdxW-1:0]           home_i,
  output logic                      res_valid_o,
  output lpht_pkg::res_t            res_o,
  input  logic                      res_ready_i
);

  localparam int CntW = $clog2(TableDepth + 1);
  localparam int WordW = lpht_pkg::KeyW + 1;
  localparam logic [IdxW-1:0] LastIdx   = IdxW'(TableDepth - 1);
  localparam logic [CntW-1:0] DepthCnt  = CntW'(TableDepth);
  localparam logic [CntW-1:0] LastCheck = CntW'(TableDepth - 1);

  typedef enum logic [4:0] {
    StClear = 5'b00001,
    StIdle  = 5'b00010,
    StHash  = 5'b00100,
    StProbe = 5'b01000,
    StDone  = 5'b10000
  } state_e;

  state_e                    state_q, state_d;
  logic [IdxW-1:0]           addr_q, addr_d;
  logic [CntW-1:0]           iss_q, iss_d;
  logic [CntW-1:0]           chk_q, chk_d;
  logic                      rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]           rd_addr_q, rd_addr_d;
  lpht_pkg::action_e         action_q;
  logic [lpht_pkg::KeyW-1:0] key_q;
  lpht_pkg::res_t            res_q, res_d;

  // Memory port signals
  logic             mem_we, mem_re;
  logic [IdxW-1:0]  mem_waddr, mem_raddr;
  logic [WordW-1:0] mem_wdata;
  logic [WordW-1:0] mem_q [TableDepth];
  logic [WordW-1:0] rdata_q;

  logic                      rd_occ;
  logic [lpht_pkg::KeyW-1:0] rd_key;
  logic                      issue;
  logic [IdxW-1:0]           addr_inc;

  assign rd_occ   = rdata_q[lpht_pkg::KeyW];
  assign rd_key   = rdata_q[lpht_pkg::KeyW-1:0];
  assign addr_inc = (addr_q == LastIdx) ? '0 : addr_q + 1'b1;
  assign issue    = (iss_q != DepthCnt);

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // Sequencer. Reads run one slot ahead of the check of returned data; the
  // only write of an item happens at its last check, and the next item's first
  // read waits for the done, idle and hash states, so no forwarding is needed.
  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    iss_d     = iss_q;
    chk_d     = chk_q;
    rd_vld_d  = 1'b0;
    rd_addr_d = rd_addr_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = rd_addr_q;
    mem_wdata = {1'b1, key_q};
    mem_re    = 1'b0;
    mem_raddr = addr_q;

    case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wdata = '0;
        addr_d    = addr_inc;
        if (addr_q == LastIdx) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (start_i) begin
          state_d = StHash;
        end
      end
      StHash: begin
        if (home_valid_i) begin
          addr_d  = home_i;
          iss_d   = '0;
          chk_d   = '0;
          state_d = StProbe;
        end
      end
      StProbe: begin
        rd_vld_d  = issue;
        rd_addr_d = addr_q;
        if (issue) begin
          mem_re = 1'b1;
          addr_d = addr_inc;
          iss_d  = iss_q + 1'b1;
        end
        if (rd_vld_q) begin
          chk_d = chk_q + 1'b1;
          if (action_q == lpht_pkg::ActInsert && !rd_occ) begin
            mem_we       = 1'b1;
            res_d.status = lpht_pkg::StInserted;
            res_d.slot   = lpht_pkg::SlotW'(rd_addr_q);
            rd_vld_d     = 1'b0;
            state_d      = StDone;
          end else if (action_q == lpht_pkg::ActSearch && rd_occ && rd_key == key_q) begin
            res_d.status = lpht_pkg::StFound;
            res_d.slot   = lpht_pkg::SlotW'(rd_addr_q);
            rd_vld_d     = 1'b0;
            state_d      = StDone;
          end else if (chk_q == LastCheck) begin
            // every slot probed without success
            res_d.status = (action_q == lpht_pkg::ActInsert) ? lpht_pkg::StFull
                                                             : lpht_pkg::StNotFound;
            res_d.slot   = '0;
            rd_vld_d     = 1'b0;
            state_d      = StDone;
          end
        end
      end
      StDone: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClear;
      addr_q   <= '0;
      iss_q    <= '0;
      chk_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      addr_q   <= addr_d;
      iss_q    <= iss_d;
      chk_q    <= chk_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    res_q     <= res_d;
    if (state_q == StIdle && start_i) begin
      action_q <= action_i;
      key_q    <= key_i;
    end
  end

  assign idle_o      = (state_q == StIdle);
  assign res_valid_o = (state_q == StDone);
  assign res_o       = res_q;

endmodule

/* rtl/core/linear_probing_hash_table_top.sv */
// Top level of the linear probing hash table: home slot unit, probe engine
// and the output register. Depends on lpht_pkg, lpht_hash and lpht_probe.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------
//   in      | into      | in_valid_i / in_ready_o | action_i, key_i
//   out     | out of    | out_valid_o/out_ready_i | status_o, slot_o
//
// One item at a time. With P slots probed (1 to TableDepth) an item passes
// the hash, probe and done states from acceptance to the next acceptance; at
// non-power-of-two depths, hash waits for the remainder (4 key bits/cycle).
// The single read port of the slot memory sets the one-slot-per-cycle probe.
// After reset a clearing pass over every slot runs with in_ready_o low.
// A result held in the output register does not block the next item; that
// item stalls only when its own result is ready and the register is still full.
`timescale 1ns / 1ps

module linear_probing_hash_table_top #(
  parameter int TableDepth = lpht_pkg::DefTableDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         action_i,
  input  logic [lpht_pkg::KeyW-1:0]    key_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [lpht_pkg::StatusW-1:0] status_o,
  output logic [lpht_pkg::SlotW-1:0]   slot_o
);

  localparam int IdxW = $clog2(TableDepth);

  logic            idle;
  logic            in_acc;
  logic            home_valid;
  logic [IdxW-1:0] home;
  logic            res_valid;
  logic            res_ready;
  lpht_pkg::res_t  res;

  logic           out_valid_q;
  lpht_pkg::res_t out_res_q;

  assign in_ready_o = idle;
  assign in_acc     = in_valid_i && idle;

  lpht_hash #(
    .TableDepth(TableDepth)
  ) u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_acc),
    .key_i  (key_i),
    .done_o (home_valid),
    .home_o (home)
  );

  lpht_probe #(
    .TableDepth(TableDepth)
  ) u_probe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .idle_o      (idle),
    .start_i     (in_acc),
    .action_i    (lpht_pkg::action_e'(action_i)),
    .key_i       (key_i),
    .home_valid_i(home_valid),
    .home_i      (home),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // Output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_res_q.status;
  assign slot_o      = out_res_q.slot;

endmodule

/* rtl/core/lpht_chk.sv */
// Port-level checker for the linear probing hash table, bound to the top.
// Depends on lpht_pkg and linear_probing_hash_table_top.
`timescale 1ns / 1ps

module lpht_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [lpht_pkg::StatusW-1:0] status_o,
  input logic [lpht_pkg::SlotW-1:0]   slot_o
);

  logic       in_acc, out_acc;
  logic [1:0] pend_q, pend_d;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign pend_d  = pend_q + {1'b0, in_acc} - {1'b0, out_acc};

  // Items accepted whose result has not been taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(slot_o))
    else $error("result changed or dropped while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result without an accepted item");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two items outstanding");

  a_busy_when_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd2 |-> !in_ready_o)
    else $error("item accepted with a result waiting and another in work");

  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == lpht_pkg::StFull || status_o == lpht_pkg::StNotFound)
      |-> slot_o == '0)
    else $error("nonzero slot on a failed item");

endmodule

bind linear_probing_hash_table_top lpht_chk u_lpht_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .status_o   (status_o),
  .slot_o     (slot_o)
);
